@@ hdl/mpe_pkg.sv @@
// Shared types, constants and CRC helpers for the multiboot payload encryptor.
// Used by mpe_core, mpe_out_fifo and multiboot_payload_encryptor; no dependencies.
package mpe_pkg;

  localparam int unsigned MAX_IMAGE_BYTES = 262144;

  localparam int WORD_W     = 32;
  localparam int CRC_W      = 16;
  localparam int OFF_W      = 18;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hc387;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hc37b;
  localparam logic [WORD_W-1:0] KEY_MUL   = 32'h6f646573;
  localparam logic [WORD_W-1:0] KEY_XOR   = 32'h43202f2f;
  localparam logic [WORD_W-1:0] ADDR_BASE = 32'h02000000;
  localparam logic [WORD_W-1:0] KEY_BASE  = 32'hffff00d1;
  localparam logic [WORD_W-1:0] FIN_HIGH  = 32'hffff0000;
  localparam logic [WORD_W-1:0] FIN_ADD   = 32'h0000000f;
  localparam logic [OFF_W-1:0]  START_OFFSET_RST = 18'd192;
  localparam logic [OFF_W:0]    OFF_LIMIT = (OFF_W+1)'(MAX_IMAGE_BYTES);
  localparam logic [OFF_W:0]    OFF_STEP  = (OFF_W+1)'(4);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PALETTE_KEY  = 2'd0,
    CFG_SEED_BYTE    = 2'd1,
    CFG_START_OFFSET = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              last;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              is_crc;
    logic              end_of_run;
  } out_t;

  typedef struct packed {
    logic valid;
    logic dual;
  } push_ctl_t;

  // Bit-serial reference fold; evaluated only on constant arguments.
  function automatic logic [CRC_W-1:0] crc_ref(logic [CRC_W-1:0] crc, logic [WORD_W-1:0] word);
    logic [CRC_W-1:0]  c;
    logic [WORD_W-1:0] w;
    c = crc;
    w = word;
    for (int k = 0; k < WORD_W; k++) begin
      if (c[0] ^ w[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      w = w >> 1;
    end
    return c;
  endfunction

  // Fold as a flat XOR network: the fold is linear in crc and word.
  function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc, logic [WORD_W-1:0] word);
    logic [CRC_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (crc[i]) begin
        acc = acc ^ crc_ref(CRC_W'(1) << i, '0);
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (word[j]) begin
        acc = acc ^ crc_ref('0, WORD_W'(1) << j);
      end
    end
    return acc;
  endfunction

endpackage

@@ hdl/multiboot_payload_encryptor.sv @@
// Multiboot payload encryptor: one plain word per request in, one encrypted word out
// per request, plus the final CRC after the word marked last. Each word passes through
// combinational logic into a four-entry result queue, so its first result can leave the
// cycle after the request is taken. A request is taken while the queue has room for two
// results and the queue delivers one per cycle: with out_ready held high ordinary words
// go through every cycle, but each last word leaves one extra result behind, so a run of
// last words cannot be taken every cycle.
// Depends on mpe_pkg, mpe_core, mpe_out_fifo.
module multiboot_payload_encryptor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mpe_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mpe_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpe_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [mpe_pkg::BYTE_W-1:0] palette_key_r;
  logic [mpe_pkg::BYTE_W-1:0] seed_byte_r;
  logic [mpe_pkg::OFF_W-1:0]  start_offset_r;

  logic               room;
  logic               take;
  mpe_pkg::push_ctl_t push;
  mpe_pkg::out_t      res_word;
  mpe_pkg::out_t      res_crc;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;
  assign take      = in_valid && room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_key_r  <= '0;
      seed_byte_r    <= '0;
      start_offset_r <= mpe_pkg::START_OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpe_pkg::CFG_PALETTE_KEY:  palette_key_r  <= cfg_data[mpe_pkg::BYTE_W-1:0];
        mpe_pkg::CFG_SEED_BYTE:    seed_byte_r    <= cfg_data[mpe_pkg::BYTE_W-1:0];
        mpe_pkg::CFG_START_OFFSET: start_offset_r <= cfg_data[mpe_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  mpe_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .in_data      (in_data),
    .palette_key  (palette_key_r),
    .seed_byte    (seed_byte_r),
    .start_offset (start_offset_r),
    .push         (push),
    .res_word     (res_word),
    .res_crc      (res_crc)
  );

  mpe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_first  (res_word),
    .wr_second (res_crc),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ hdl/mpe_core.sv @@
// Run state and datapath: CRC, keystream, byte offset; builds one or two results per word.
// Depends on mpe_pkg.
module mpe_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      take,
  input  mpe_pkg::in_t              in_data,
  input  logic [mpe_pkg::BYTE_W-1:0] palette_key,
  input  logic [mpe_pkg::BYTE_W-1:0] seed_byte,
  input  logic [mpe_pkg::OFF_W-1:0]  start_offset,
  output mpe_pkg::push_ctl_t        push,
  output mpe_pkg::out_t             res_word,
  output mpe_pkg::out_t             res_crc
);

  logic [mpe_pkg::CRC_W-1:0]  crc_r, crc_nxt;
  logic [mpe_pkg::WORD_W-1:0] key_r, key_nxt;
  logic [mpe_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic                       at_start_r, at_start_nxt;

  logic [mpe_pkg::WORD_W-1:0] key_cur;
  logic [mpe_pkg::OFF_W-1:0]  off_cur;
  logic [mpe_pkg::CRC_W-1:0]  crc_run;
  logic [mpe_pkg::CRC_W-1:0]  crc_fin;
  logic [mpe_pkg::WORD_W-1:0] fin_val;
  logic [mpe_pkg::WORD_W-1:0] addr;
  logic [mpe_pkg::OFF_W:0]    off_sum;

  always_comb begin
    key_cur = at_start_r
            ? mpe_pkg::KEY_BASE + {{(mpe_pkg::WORD_W-mpe_pkg::BYTE_W-8){1'b0}}, palette_key, 8'h00}
            : key_r;
    off_cur = at_start_r ? start_offset : off_r;

    crc_run = mpe_pkg::crc_fold(crc_r, in_data.data_word);
    key_nxt = key_cur * mpe_pkg::KEY_MUL + mpe_pkg::WORD_W'(1);
    addr    = mpe_pkg::ADDR_BASE + mpe_pkg::WORD_W'(off_cur);

    fin_val = (mpe_pkg::WORD_W'({seed_byte, 8'h00}) + mpe_pkg::WORD_W'(palette_key)
               + mpe_pkg::FIN_ADD) | mpe_pkg::FIN_HIGH;
    crc_fin = mpe_pkg::crc_fold(crc_run, fin_val);

    off_sum = {1'b0, off_cur} + mpe_pkg::OFF_STEP;
    off_nxt = (off_sum >= mpe_pkg::OFF_LIMIT) ? '0 : off_sum[mpe_pkg::OFF_W-1:0];

    crc_nxt      = in_data.last ? mpe_pkg::CRC_INIT : crc_run;
    at_start_nxt = in_data.last;

    res_word.out_word   = in_data.data_word ^ (mpe_pkg::WORD_W'(0) - addr) ^ key_nxt
                          ^ mpe_pkg::KEY_XOR;
    res_word.is_crc     = 1'b0;
    res_word.end_of_run = !in_data.last;

    res_crc.out_word    = mpe_pkg::WORD_W'(crc_fin);
    res_crc.is_crc      = 1'b1;
    res_crc.end_of_run  = 1'b1;

    push.valid = take;
    push.dual  = take && in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= mpe_pkg::CRC_INIT;
      key_r      <= '0;
      off_r      <= '0;
      at_start_r <= 1'b1;
    end else if (take) begin
      crc_r      <= crc_nxt;
      key_r      <= key_nxt;
      off_r      <= off_nxt;
      at_start_r <= at_start_nxt;
    end
  end

endmodule

@@ hdl/mpe_out_fifo.sv @@
// Four-entry result queue; takes one or two results per cycle, delivers one while out_ready is high.
// Depends on mpe_pkg.
module mpe_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  mpe_pkg::push_ctl_t push,
  input  mpe_pkg::out_t      wr_first,
  input  mpe_pkg::out_t      wr_second,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output mpe_pkg::out_t      out_data
);

  mpe_pkg::out_t mem_r [mpe_pkg::FIFO_DEPTH];

  logic [mpe_pkg::PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mpe_pkg::PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mpe_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [mpe_pkg::PTR_W-1:0] wr_ptr_plus1;
  logic                      pop;

  always_comb begin
    pop          = out_valid && out_ready;
    wr_ptr_plus1 = wr_ptr_r + mpe_pkg::PTR_W'(1);
    wr_ptr_nxt   = wr_ptr_r;
    if (push.valid) begin
      wr_ptr_nxt = push.dual ? wr_ptr_r + mpe_pkg::PTR_W'(2) : wr_ptr_plus1;
    end
    rd_ptr_nxt = pop ? rd_ptr_r + mpe_pkg::PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r
               + (push.valid ? mpe_pkg::CNT_W'(1) : '0)
               + (push.dual  ? mpe_pkg::CNT_W'(1) : '0)
               - (pop        ? mpe_pkg::CNT_W'(1) : '0);
  end

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign room      = (count_r <= mpe_pkg::CNT_W'(mpe_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= wr_first;
    end
    if (push.dual) begin
      mem_r[wr_ptr_plus1] <= wr_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mpe_pkg::CNT_W'(mpe_pkg::FIFO_DEPTH))
    else $error("result queue count exceeds depth");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> count_r <= mpe_pkg::CNT_W'(mpe_pkg::FIFO_DEPTH - 2))
    else $error("result pushed without room for two");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push.valid) |=> count_r == $past(count_r) - mpe_pkg::CNT_W'(1))
    else $error("count did not drop after pop");

endmodule
